// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the sorted profile merge core.
// No dependencies; define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property holds on every clock edge outside reset.
`define SPMA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Expression never holds on any clock edge outside reset.
`define SPMA_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define SPMA_ASSERT(lbl, prop)
`define SPMA_NEVER(lbl, expr)
`endif
`endif

// File: src/spma_pkg.sv
// Package for the sorted profile merge core: sizes, codes and cell interface types.
// No dependencies; used by every module in src.
package spma_pkg;

    localparam int DEPTH      = 256;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMP_W      = (CNT_W > 9) ? CNT_W : 9;
    localparam int TIME_W     = 32;
    localparam int INT_W      = 32;
    localparam int SUM_W      = 40;
    localparam int GROUP      = 64;
    localparam int NUM_GROUPS = (DEPTH + GROUP - 1) / GROUP;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_ADD   = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic              eval;      // compare cycle of an add
        logic              apply;     // update cycle of an add
        logic              clear;     // drop all entries, cursor to zero
        logic              ao;        // append without compare
        logic              ts;        // trace start: cursor restarts
        logic              merge_any; // some cell holds an equal key at the stop
        logic              ins_go;    // insert or append goes ahead
        logic [TIME_W-1:0] t;
        logic [INT_W-1:0]  v;
        logic [CMP_W-1:0]  count;
        logic [CMP_W-1:0]  ridx;
    } cell_ctl_t;

    // Handed from a cell to its right neighbor.
    typedef struct packed {
        logic              stop_now;
        logic              stop_q;
        logic [TIME_W-1:0] time_key;
        logic [SUM_W-1:0]  sum;
    } cell_link_t;

endpackage

// File: src/spma_cell.sv
// One profile cell: holds one entry and its cursor mark, shifts right on insert.
// Depends on spma_pkg.
module spma_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [spma_pkg::CMP_W-1:0] idx,
    input  spma_pkg::cell_ctl_t        ctl,
    input  spma_pkg::cell_link_t       prev,
    output spma_pkg::cell_link_t       link,
    output logic                       hit,
    output logic                       past,
    output logic                       active,
    output logic [spma_pkg::TIME_W-1:0] rd_time,
    output logic [spma_pkg::SUM_W-1:0]  rd_sum
);

    logic [spma_pkg::TIME_W-1:0] time_reg;
    logic [spma_pkg::SUM_W-1:0]  sum_reg;
    logic                        past_reg;
    logic                        stop_reg;
    logic                        hit_reg;

    logic                        past_eff;
    logic                        stop_c;
    logic                        stop_seen;
    logic                        eq;
    logic                        first;
    logic [spma_pkg::SUM_W:0]    sum_wide;
    logic [spma_pkg::SUM_W-1:0]  sum_sat;

    assign active   = idx < ctl.count;
    assign past_eff = ctl.ts ? 1'b0 : past_reg;
    assign eq       = time_reg == ctl.t;
    assign stop_c   = ctl.ao ? !active
                             : (!past_eff && (!active || time_reg >= ctl.t));
    // stop lies here or somewhere to the left; keys need not be sorted
    assign stop_seen = stop_c || prev.stop_now;
    assign first    = stop_reg && !prev.stop_q;
    assign sum_wide = {1'b0, sum_reg} + (spma_pkg::SUM_W + 1)'(ctl.v);
    assign sum_sat  = sum_wide[spma_pkg::SUM_W] ? spma_pkg::SUM_MAX
                                                : sum_wide[spma_pkg::SUM_W-1:0];

    // Control marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            past_reg <= 1'b0;
            stop_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.eval)
            begin
                stop_reg <= stop_seen;
                hit_reg  <= stop_c && !prev.stop_now && active && eq && !ctl.ao;
            end
            if (ctl.clear)
            begin
                past_reg <= 1'b0;
            end
            else if (ctl.apply && !ctl.ao)
            begin
                // cursor lands one past the stop unless a full profile dropped the peak
                past_reg <= (ctl.ins_go || ctl.merge_any) ? !prev.stop_q : !stop_reg;
            end
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (ctl.apply)
        begin
            if (ctl.ins_go)
            begin
                if (first)
                begin
                    time_reg <= ctl.t;
                    sum_reg  <= spma_pkg::SUM_W'(ctl.v);
                end
                else if (prev.stop_q)
                begin
                    time_reg <= prev.time_key;
                    sum_reg  <= prev.sum;
                end
            end
            else if (ctl.merge_any && hit_reg)
            begin
                sum_reg <= sum_sat;
            end
        end
    end

    assign link.stop_now = stop_seen;
    assign link.stop_q   = stop_reg;
    assign link.time_key = time_reg;
    assign link.sum      = sum_reg;
    assign hit           = hit_reg;
    assign past          = past_reg;
    assign rd_time       = (idx == ctl.ridx) ? time_reg : '0;
    assign rd_sum        = (idx == ctl.ridx) ? sum_reg  : '0;

endmodule

// File: src/spma_rd_group.sv
// Registered OR of one group of cell read taps; only the addressed cell is nonzero.
// Depends on spma_pkg.
module spma_rd_group
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [spma_pkg::TIME_W-1:0] time_in [spma_pkg::GROUP],
    input  logic [spma_pkg::SUM_W-1:0]  sum_in  [spma_pkg::GROUP],
    output logic [spma_pkg::TIME_W-1:0] time_out,
    output logic [spma_pkg::SUM_W-1:0]  sum_out
);

    logic [spma_pkg::TIME_W-1:0] time_or;
    logic [spma_pkg::SUM_W-1:0]  sum_or;

    always_comb
    begin
        time_or = '0;
        sum_or  = '0;
        for (int i = 0; i < spma_pkg::GROUP; i++)
        begin
            time_or = time_or | time_in[i];
            sum_or  = sum_or  | sum_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            time_out <= time_or;
            sum_out  <= sum_or;
        end
    end

endmodule

// File: src/sorted_profile_merge_accumulate_core.sv
// Sorted profile merge core: a row of DEPTH cells keeps (time, sum) entries in
// time order together with a thermometer cursor. An add peak runs a compare and
// an update: each cell compares its key against the peak, a stop flag runs along
// the row so that every cell registers whether the first stop lies at or before
// it, then every cell past the stop shifts right by one and the stop cell takes
// the peak, or the stop cell adds the intensity to an equal key with saturation
// at 2^40-1; a full row drops a peak with no equal key. A new transfer is taken
// in the update cycle, so the next add can start while the current one finishes.
// A read registers an OR over groups of 64 cells, then ORs across groups into the
// result; clear and the unused code go straight to the update. A result waits in
// an output register; the block stalls in its update cycle while that register
// is occupied and not being taken. Entry storage has no reset and no clearing
// pass: only entries below the count are ever read.
// Depends on spma_pkg, spma_cell, spma_rd_group and assert_macros.svh.
`include "assert_macros.svh"

module sorted_profile_merge_accumulate_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic        append_only,
    input  logic        trace_start,
    input  logic [31:0] peak_time,
    input  logic [31:0] peak_intensity,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [8:0]  entry_total,
    output logic [31:0] read_time,
    output logic [39:0] read_sum
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_RD    = 4'b0100,
        S_APPLY = 4'b1000
    } state_t;

    localparam int PAD = spma_pkg::NUM_GROUPS * spma_pkg::GROUP;

    state_t state_reg, state_next;

    // request held for the item at work
    logic [1:0]                  func_reg;
    logic                        ao_reg;
    logic                        ts_reg;
    logic [spma_pkg::TIME_W-1:0] t_reg;
    logic [spma_pkg::INT_W-1:0]  v_reg;
    logic [7:0]                  ridx_reg;

    logic [spma_pkg::CMP_W-1:0]  cnt_reg, cnt_next;
    logic [spma_pkg::CMP_W-1:0]  cnt_inc;

    logic                        out_valid_reg;
    logic [1:0]                  status_reg;
    logic [8:0]                  total_reg;
    logic [spma_pkg::TIME_W-1:0] rtime_reg;
    logic [spma_pkg::SUM_W-1:0]  rsum_reg;

    logic                        accept;
    logic                        out_free;
    logic                        finish;
    logic                        full;
    logic                        merge_any;
    logic                        in_range;
    logic [1:0]                  status_c;
    logic [spma_pkg::TIME_W-1:0] rtime_c;
    logic [spma_pkg::SUM_W-1:0]  rsum_c;
    logic [spma_pkg::CMP_W-1:0]  ridx_ext;

    spma_pkg::cell_ctl_t         ctl;
    spma_pkg::cell_link_t        links [spma_pkg::DEPTH+1];
    logic [spma_pkg::DEPTH-1:0]  hit_vec;
    logic [spma_pkg::DEPTH-1:0]  past_vec;
    logic [spma_pkg::DEPTH-1:0]  active_vec;
    logic [spma_pkg::TIME_W-1:0] tap_time [PAD];
    logic [spma_pkg::SUM_W-1:0]  tap_sum  [PAD];
    logic [spma_pkg::TIME_W-1:0] grp_time [spma_pkg::NUM_GROUPS];
    logic [spma_pkg::SUM_W-1:0]  grp_sum  [spma_pkg::NUM_GROUPS];

    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (state_reg == S_APPLY) && out_free;
    assign in_ready = (state_reg == S_IDLE) || finish;
    assign accept   = in_valid && in_ready;
    assign full     = cnt_reg == spma_pkg::CMP_W'(spma_pkg::DEPTH);
    assign merge_any = |hit_vec;
    assign ridx_ext = spma_pkg::CMP_W'(ridx_reg);
    assign cnt_inc  = cnt_reg + spma_pkg::CMP_W'(1);

    // Broadcast to the cells; the update fires only when the result can be taken
    always_comb
    begin
        ctl           = '0;
        ctl.eval      = state_reg == S_EVAL;
        ctl.apply     = finish && (func_reg == spma_pkg::FN_ADD);
        ctl.clear     = finish && (func_reg == spma_pkg::FN_CLEAR);
        ctl.ao        = ao_reg;
        ctl.ts        = ts_reg;
        ctl.merge_any = merge_any;
        ctl.ins_go    = !merge_any && !full;
        ctl.t         = t_reg;
        ctl.v         = v_reg;
        ctl.count     = cnt_reg;
        ctl.ridx      = ridx_ext;
    end

    // Row of cells; the left end sees no stop so cell zero never shifts in
    assign links[0] = '0;

    for (genvar i = 0; i < spma_pkg::DEPTH; i++)
    begin : g_cell
        spma_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (spma_pkg::CMP_W'(i)),
            .ctl     (ctl),
            .prev    (links[i]),
            .link    (links[i+1]),
            .hit     (hit_vec[i]),
            .past    (past_vec[i]),
            .active  (active_vec[i]),
            .rd_time (tap_time[i]),
            .rd_sum  (tap_sum[i])
        );
    end

    for (genvar i = spma_pkg::DEPTH; i < PAD; i++)
    begin : g_pad
        assign tap_time[i] = '0;
        assign tap_sum[i]  = '0;
    end

    for (genvar g = 0; g < spma_pkg::NUM_GROUPS; g++)
    begin : g_grp
        spma_rd_group u_grp
        (
            .clk      (clk),
            .en       (state_reg == S_RD),
            .time_in  (tap_time[g*spma_pkg::GROUP +: spma_pkg::GROUP]),
            .sum_in   (tap_sum[g*spma_pkg::GROUP +: spma_pkg::GROUP]),
            .time_out (grp_time[g]),
            .sum_out  (grp_sum[g])
        );
    end

    // Result of the item in its update cycle
    always_comb
    begin
        rtime_c  = '0;
        rsum_c   = '0;
        status_c = spma_pkg::ST_OK;
        cnt_next = cnt_reg;
        in_range = ridx_ext < cnt_reg;
        unique case (func_reg)
            spma_pkg::FN_CLEAR:
            begin
                cnt_next = '0;
            end
            spma_pkg::FN_ADD:
            begin
                if (!merge_any)
                begin
                    if (full)
                    begin
                        status_c = spma_pkg::ST_FULL;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            spma_pkg::FN_READ:
            begin
                if (in_range)
                begin
                    for (int g = 0; g < spma_pkg::NUM_GROUPS; g++)
                    begin
                        rtime_c = rtime_c | grp_time[g];
                        rsum_c  = rsum_c  | grp_sum[g];
                    end
                end
                else
                begin
                    status_c = spma_pkg::ST_RANGE;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Sequencer: add goes through compare then update, read through the group OR
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_EVAL:
            begin
                state_next = S_APPLY;
            end
            S_RD:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = finish ? S_IDLE : S_APPLY;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (accept)
        begin
            priority case (func)
                spma_pkg::FN_ADD:  state_next = S_EVAL;
                spma_pkg::FN_READ: state_next = S_RD;
                default:           state_next = S_APPLY;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            func_reg      <= spma_pkg::FN_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                func_reg <= func;
            end
            if (finish)
            begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ao_reg   <= append_only;
            ts_reg   <= trace_start;
            t_reg    <= peak_time;
            v_reg    <= peak_intensity;
            ridx_reg <= read_index;
        end
        if (finish)
        begin
            status_reg <= status_c;
            total_reg  <= cnt_next[8:0];
            rtime_reg  <= rtime_c;
            rsum_reg   <= rsum_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_total = total_reg;
    assign read_time   = rtime_reg;
    assign read_sum    = rsum_reg;

    `SPMA_NEVER(a_cnt_over, cnt_reg > spma_pkg::CMP_W'(spma_pkg::DEPTH))
    `SPMA_ASSERT(a_cnt_step, $changed(cnt_reg) |-> (cnt_reg == $past(cnt_inc) || cnt_reg == '0))
    `SPMA_NEVER(a_cursor_past_count, |(past_vec & ~active_vec))
    `SPMA_ASSERT(a_result_from_update, $rose(out_valid_reg) |-> $past(state_reg == S_APPLY))
    `SPMA_ASSERT(a_drop_when_full, (out_valid_reg && status_reg == spma_pkg::ST_FULL) |-> full)

endmodule

// File: tb/profile_checker.sv
// Checker for the sorted profile merge core: watches the input and output channels,
// keeps its own copy of the profile and compares every result with the predicted one.
// Depends on spma_pkg for sizes and codes.
`timescale 1ns / 100ps

module profile_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  func,
    input  logic        append_only,
    input  logic        trace_start,
    input  logic [31:0] peak_time,
    input  logic [31:0] peak_intensity,
    input  logic [7:0]  read_index,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [8:0]  entry_total,
    input  logic [31:0] read_time,
    input  logic [39:0] read_sum,
    output int          failures,
    output int          outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  total;
        logic [31:0] rtime;
        logic [39:0] rsum;
    } profile_result_t;

    logic [31:0]     key_mem [spma_pkg::DEPTH];
    logic [39:0]     sum_mem [spma_pkg::DEPTH];
    int              n_entries;
    int              walk_pos;
    int              reported;
    profile_result_t expected_q [$];
    profile_result_t want;
    profile_result_t got;

    task automatic append_entry(input logic [31:0] t, input logic [31:0] v,
                                output logic [1:0] st);
        if (n_entries >= spma_pkg::DEPTH)
        begin
            st = spma_pkg::ST_FULL;
        end
        else
        begin
            key_mem[n_entries] = t;
            sum_mem[n_entries] = {8'd0, v};
            n_entries++;
            st = spma_pkg::ST_OK;
        end
    endtask

    // Apply one transfer to the local profile and work out the result it gives.
    task automatic predict_profile(input logic [1:0] fn, input logic ao, input logic ts,
                                   input logic [31:0] t, input logic [31:0] v,
                                   input logic [7:0] idx, output profile_result_t r);
        logic [40:0] acc;
        int          k;
        r = '0;
        r.status = spma_pkg::ST_OK;
        if (fn == spma_pkg::FN_CLEAR)
        begin
            n_entries = 0;
            walk_pos  = 0;
        end
        else if (fn == spma_pkg::FN_ADD)
        begin
            if (ao)
            begin
                append_entry(t, v, r.status);
            end
            else
            begin
                if (ts)
                    walk_pos = 0;
                if (walk_pos > n_entries)
                    walk_pos = n_entries;
                while (walk_pos < n_entries && key_mem[walk_pos] < t)
                    walk_pos++;
                if (walk_pos >= n_entries)
                begin
                    append_entry(t, v, r.status);
                    walk_pos = n_entries;
                end
                else if (key_mem[walk_pos] > t)
                begin
                    if (n_entries >= spma_pkg::DEPTH)
                    begin
                        r.status = spma_pkg::ST_FULL;
                    end
                    else
                    begin
                        // shift the tail right by one, then drop the peak into the gap
                        for (k = n_entries; k > walk_pos; k--)
                        begin
                            key_mem[k] = key_mem[k-1];
                            sum_mem[k] = sum_mem[k-1];
                        end
                        key_mem[walk_pos] = t;
                        sum_mem[walk_pos] = {8'd0, v};
                        n_entries++;
                        walk_pos++;
                    end
                end
                else
                begin
                    acc = {1'b0, sum_mem[walk_pos]} + {9'd0, v};
                    sum_mem[walk_pos] = (acc > {1'b0, spma_pkg::SUM_MAX}) ? spma_pkg::SUM_MAX
                                                                          : acc[39:0];
                    walk_pos++;
                end
            end
        end
        else if (fn == spma_pkg::FN_READ)
        begin
            if (int'(idx) >= n_entries)
            begin
                r.status = spma_pkg::ST_RANGE;
            end
            else
            begin
                r.rtime = key_mem[idx];
                r.rsum  = sum_mem[idx];
            end
        end
        r.total = n_entries[8:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_entries = 0;
            walk_pos  = 0;
            reported  = 0;
            failures  = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_profile(func, append_only, trace_start, peak_time,
                                peak_intensity, read_index, want);
                expected_q = {expected_q, want};
            end
            if (out_valid && out_ready)
            begin
                got = '{status, entry_total, read_time, read_sum};
                if (expected_q.size() == 0)
                begin
                    failures++;
                    if (reported < 10)
                    begin
                        reported++;
                        $display("%0t: unexpected result: status %0d total %0d time %h sum %h",
                                 $time, got.status, got.total, got.rtime, got.rsum);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        failures++;
                        if (reported < 10)
                        begin
                            reported++;
                            $display("%0t: expected status %0d total %0d time %h sum %h",
                                     $time, want.status, want.total, want.rtime, want.rsum);
                            $display("%0t: actual   status %0d total %0d time %h sum %h",
                                     $time, got.status, got.total, got.rtime, got.rsum);
                        end
                    end
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
// Top of the sorted profile merge testbench: clock, reset, transfer stimulus and verdict.
// Depends on spma_pkg, the core and profile_checker, which does all prediction.
`timescale 1ns / 100ps

module testbench;

    // func code with no meaning to the block: it must change nothing
    localparam logic [1:0] FN_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  func;
    logic        append_only;
    logic        trace_start;
    logic [31:0] peak_time;
    logic [31:0] peak_intensity;
    logic [7:0]  read_index;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [8:0]  entry_total;
    logic [31:0] read_time;
    logic [39:0] read_sum;
    int          failures;
    int          outstanding;

    int items_sent  = 0;
    int tx_idle_pct = 7;
    int rx_idle_pct = 48;

    sorted_profile_merge_accumulate_core u_dut (.*);

    profile_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #200000;
        $display("simulation failed");
        $finish;
    end

    // Offer one item and hold it until the block takes it.
    task automatic transfer_item(input logic [1:0] fn, input logic ao, input logic ts,
                                 input logic [31:0] t, input logic [31:0] v,
                                 input logic [7:0] idx);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= fn;
        append_only    <= ao;
        trace_start    <= ts;
        peak_time      <= t;
        peak_intensity <= v;
        read_index     <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        // idle mix: sender light and receiver heavy, then swapped, then none
        if (items_sent < 270)
        begin
            tx_idle_pct = 7;
            rx_idle_pct = 48;
        end
        else if (items_sent < 540)
        begin
            tx_idle_pct = 48;
            rx_idle_pct = 7;
        end
        else
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic add_peak(input logic ao, input logic ts, input logic [31:0] t,
                            input logic [31:0] v);
        transfer_item(spma_pkg::FN_ADD, ao, ts, t, v, 8'($urandom));
    endtask

    task automatic read_entry(input logic [7:0] idx);
        transfer_item(spma_pkg::FN_READ, 1'($urandom), 1'($urandom), $urandom, $urandom,
                      idx);
    endtask

    task automatic clear_profile();
        transfer_item(spma_pkg::FN_CLEAR, 1'($urandom), 1'($urandom), $urandom, $urandom,
                      8'($urandom));
    endtask

    task automatic unused_code();
        transfer_item(FN_UNUSED, 1'($urandom), 1'($urandom), $urandom, $urandom,
                      8'($urandom));
    endtask

    // Mix reads, the unused code and stray peaks into the traces now and then.
    task automatic interleave_other();
        int pick;
        pick = $urandom_range(99);
        if (pick < 12)
            read_entry(8'($urandom_range(20)));
        else if (pick < 15)
            read_entry(8'($urandom));
        else if (pick < 17)
            unused_code();
        else if (pick < 21)
            add_peak(1'($urandom), 1'($urandom), $urandom, $urandom);
    endtask

    // One profile: a first trace appended as is, then a few sorted traces merged in.
    task automatic random_build();
        int          n_first;
        int          n_traces;
        int          n_peaks;
        logic [31:0] t_cur;
        logic [31:0] t_peak;
        if ($urandom_range(99) < 80)
            clear_profile();
        n_first = $urandom_range(10);
        t_cur   = 32'($urandom_range(3)) << 12;
        for (int i = 0; i < n_first; i++)
        begin
            interleave_other();
            add_peak(1'b1, 1'($urandom), t_cur, $urandom);
            t_cur += 32'($urandom_range(3)) << 12;
        end
        n_traces = $urandom_range(1, 4);
        for (int tr = 0; tr < n_traces; tr++)
        begin
            t_cur   = 32'($urandom_range(4)) << 12;
            n_peaks = $urandom_range(1, 10);
            for (int p = 0; p < n_peaks; p++)
            begin
                interleave_other();
                t_peak = t_cur;
                // off-grid key now and then, so inserts land between equal-key merges
                if ($urandom_range(3) == 0)
                    t_peak += 32'($urandom_range(1, 12'hFFF));
                add_peak(1'b0, p == 0, t_peak, $urandom);
                t_cur += 32'($urandom_range(3)) << 12;
            end
        end
    endtask

    // Receiver: random stalls, plus one long hold-off so the core backs up.
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= 100)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin : stimulus
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        func           <= spma_pkg::FN_CLEAR;
        append_only    <= 1'b0;
        trace_start    <= 1'b0;
        peak_time      <= '0;
        peak_intensity <= '0;
        read_index     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty read, unused code, append-only with trace start,
        // merge, insert, append past the end and after an append, key extremes.
        read_entry(8'd0);
        unused_code();
        add_peak(1'b1, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        add_peak(1'b1, 1'b1, 32'h0001_0000, 32'd5);
        add_peak(1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_peak(1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
        add_peak(1'b0, 1'b0, 32'h0000_8000, 32'd7);
        add_peak(1'b0, 1'b0, 32'h0001_0000, 32'hFFFF_FFFF);
        add_peak(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_peak(1'b0, 1'b0, 32'hFFFF_FFFF, 32'd3);
        add_peak(1'b0, 1'b0, 32'd5, 32'd9);
        add_peak(1'b0, 1'b1, 32'd5, 32'd1);
        read_entry(8'd0);
        read_entry(8'd1);
        read_entry(8'd6);
        read_entry(8'd7);
        read_entry(8'hFF);
        clear_profile();
        read_entry(8'd0);
        add_peak(1'b0, 1'b1, 32'h1234_5678, 32'hA5A5_A5A5);
        unused_code();
        read_entry(8'd0);

        while (items_sent < 150)
            random_build();

        // Fill to capacity: integer keys appended, then half-step keys inserted
        // between them until the profile is full and further inserts are dropped.
        clear_profile();
        for (int i = 0; i < 200; i++)
            add_peak(1'b1, i == 0, 32'(i) << 16, $urandom);
        for (int i = 0; i < 70; i++)
            add_peak(1'b0, i == 0, 32'(2 * i + 1) << 15, $urandom);
        // at full: merge still goes ahead, insert and both appends are dropped
        add_peak(1'b0, 1'b1, 32'h0003_0000, $urandom);
        add_peak(1'b0, 1'b0, 32'h0003_4000, $urandom);
        add_peak(1'b0, 1'b0, 32'hFFFF_FFFF, $urandom);
        add_peak(1'b1, 1'b0, 32'hFFFF_FFFF, $urandom);
        read_entry(8'd255);
        read_entry(8'd128);
        // drive the first sum past 40 bits so it saturates
        for (int i = 0; i < 258; i++)
            add_peak(1'b0, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
        read_entry(8'd0);
        read_entry(8'd1);

        while (items_sent < 735)
            random_build();

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
